// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the cache top
// depends on a clock named clk and a reset named rst in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every cycle out of reset
`define FVC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FVC_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/fvc_pkg.sv =====
// shared types, codes and helpers for the flow verdict cache
// no dependencies
package fvc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int TAG_W   = 16;

  // action codes on the input port
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_BADV = 2'd2;

  // redirect source codes
  localparam logic [1:0] RS_NONE = 2'd0;
  localparam logic [1:0] RS_TAG  = 2'd1;
  localparam logic [1:0] RS_PKT  = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_MISS        = 3'd0;
  localparam logic [2:0] CFG_DNS_CODE    = 3'd1;
  localparam logic [2:0] CFG_TUNNEL_CODE = 3'd2;
  localparam logic [2:0] CFG_TUNNEL_PORT = 3'd3;
  localparam logic [2:0] CFG_DNS_PORT    = 3'd4;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_ADD,
    OP_BAD_ADD,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [7:0]  miss_code;
    logic [7:0]  dns_code;
    logic [7:0]  tunnel_code;
    logic [15:0] tunnel_port;
    logic [15:0] dns_port;
  } cfg_t;

  typedef struct packed {
    logic [63:0] lhi;
    logic [63:0] llo;
    logic [63:0] rhi;
    logic [63:0] rlo;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [7:0]  proto;
  } key_t;

  typedef struct packed {
    op_t             op;
    logic            rev;
    key_t            key;
    logic [7:0]      nv;
    logic [TAG_W-1:0] tag;
  } item_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] used;
  } stat_t;

  function automatic logic is_redir(logic [7:0] v, cfg_t c);
    return (v == c.dns_code) || (v == c.tunnel_code);
  endfunction

endpackage

// ===== rtl/fvc_front.sv =====
// front end: configuration registers, item acceptance and classification
// depends on fvc_pkg
module fvc_front import fvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] local_addr_hi,
  input  logic [63:0] local_addr_lo,
  input  logic [63:0] remote_addr_hi,
  input  logic [63:0] remote_addr_lo,
  input  logic [15:0] local_port,
  input  logic [15:0] remote_port,
  input  logic [7:0]  protocol,
  input  logic        inbound,
  input  logic [7:0]  new_verdict,
  input  logic [15:0] context_tag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        q_full,
  output logic        push,
  output item_t       item,
  output cfg_t        cfg
);

  // register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.miss_code   <= 8'd0;
      cfg.dns_code    <= 8'd1;
      cfg.tunnel_code <= 8'd2;
      cfg.tunnel_port <= 16'd0;
      cfg.dns_port    <= 16'd53;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MISS:        cfg.miss_code   <= cfg_data[7:0];
        CFG_DNS_CODE:    cfg.dns_code    <= cfg_data[7:0];
        CFG_TUNNEL_CODE: cfg.tunnel_code <= cfg_data[7:0];
        CFG_TUNNEL_PORT: cfg.tunnel_port <= cfg_data;
        CFG_DNS_PORT:    cfg.dns_port    <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept a beat whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify the item
  always_comb begin
    item.key.lhi   = local_addr_hi;
    item.key.llo   = local_addr_lo;
    item.key.rhi   = remote_addr_hi;
    item.key.rlo   = remote_addr_lo;
    item.key.lport = local_port;
    item.key.rport = remote_port;
    item.key.proto = protocol;
    item.nv        = new_verdict;
    item.tag       = context_tag[TAG_W-1:0];
    item.rev       = inbound &&
                     ((remote_port == cfg.tunnel_port) || (remote_port == cfg.dns_port));
    case (action)
      ACT_LOOKUP: item.op = OP_LOOKUP;
      ACT_ADD:    item.op = (new_verdict == 8'd0) ? OP_BAD_ADD : OP_ADD;
      ACT_CLEAR:  item.op = OP_CLEAR;
      default:    item.op = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/fvc_queue.sv =====
// two-entry queue between the front end and the engine
// depends on fvc_pkg
module fvc_queue import fvc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== rtl/fvc_back.sv =====
// engine: entry memories, slot scans, eviction search and result register
// depends on fvc_pkg
module fvc_back import fvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  item_t       q_item,
  input  logic        q_empty,
  output logic        pop,
  output stat_t       stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  verdict,
  output logic [1:0]  redirect_source,
  output logic [15:0] redirect_tag,
  output logic        evicted_valid,
  output logic [15:0] evicted_tag
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REV_SCAN,
    S_FULL_SCAN,
    S_DUP_SCAN,
    S_EVICT_SCAN,
    S_WRITE,
    S_RESP
  } state_t;

  state_t state;

  // entry memories
  key_t             key_mem   [ENTRIES];
  logic [7:0]       ver_mem   [ENTRIES];
  logic [TAG_W-1:0] tag_mem   [ENTRIES];
  logic [63:0]      stamp_mem [ENTRIES];
  logic [ENTRIES-1:0] mark;

  key_t             key_rd;
  logic [7:0]       ver_rd;
  logic [TAG_W-1:0] tag_rd;
  logic [63:0]      stamp_rd;

  item_t            cur;
  logic [CNT_W-1:0] used;
  logic [63:0]      acc;

  // scan control
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] scan_n;
  logic             rd_v;
  logic [IDX_W-1:0] rd_idx;
  logic             scan_done;

  // first hit or running minimum
  logic             found;
  logic [IDX_W-1:0] fidx;
  logic [7:0]       fver;
  logic [TAG_W-1:0] ftag;
  logic [63:0]      fmin;
  logic             rfound;
  logic [IDX_W-1:0] rslot;

  logic [IDX_W-1:0] wslot;

  // result being built
  logic [1:0]       r_status;
  logic [7:0]       r_verdict;
  logic [1:0]       r_rsrc;
  logic [TAG_W-1:0] r_rtag;
  logic             r_evv;
  logic [TAG_W-1:0] r_evt;

  logic             full_hit;
  logic             rdir_hit;
  logic [7:0]       hit_v;
  logic [7:0]       rev_v;
  logic             stamp_we;
  logic [IDX_W-1:0] stamp_waddr;
  logic             new_mark;

  assign scan_done = (idx >= scan_n) && !rd_v;
  assign full_hit  = (key_rd == cur.key);
  assign rdir_hit  = mark[rd_idx] && (key_rd.lhi == cur.key.lhi) &&
                     (key_rd.llo == cur.key.llo) && (key_rd.lport == cur.key.lport) &&
                     (key_rd.proto == cur.key.proto);
  assign hit_v     = found ? fver : cfg.miss_code;
  assign rev_v     = is_redir(hit_v, cfg) ? hit_v : cfg.miss_code;
  assign new_mark  = is_redir(cur.nv, cfg) && !(rfound && !(r_evv && (rslot == wslot)));

  assign pop  = (state == S_IDLE) && !q_empty;
  assign stat.busy = (state != S_IDLE);
  assign stat.used = used;

  // stamp update: refresh on a lookup hit, set on a new entry
  always_comb begin
    stamp_we    = 1'b0;
    stamp_waddr = fidx;
    if (state == S_WRITE) begin
      stamp_we    = 1'b1;
      stamp_waddr = wslot;
    end else if ((state == S_REV_SCAN || state == S_FULL_SCAN) && scan_done && found) begin
      stamp_we = 1'b1;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    key_rd   <= key_mem[idx[IDX_W-1:0]];
    ver_rd   <= ver_mem[idx[IDX_W-1:0]];
    tag_rd   <= tag_mem[idx[IDX_W-1:0]];
    stamp_rd <= stamp_mem[idx[IDX_W-1:0]];
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      key_mem[wslot] <= cur.key;
      ver_mem[wslot] <= cur.nv;
      tag_mem[wslot] <= cur.tag;
    end
    if (stamp_we) stamp_mem[stamp_waddr] <= acc;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      acc       <= 64'd0;
      mark      <= '0;
      idx       <= '0;
      scan_n    <= '0;
      rd_v      <= 1'b0;
      found     <= 1'b0;
      rfound    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESP) out_valid <= 1'b0;

      // one slot per cycle in any scan state
      if (state == S_REV_SCAN || state == S_FULL_SCAN ||
          state == S_DUP_SCAN || state == S_EVICT_SCAN) begin
        if (idx < scan_n) begin
          rd_v   <= 1'b1;
          rd_idx <= idx[IDX_W-1:0];
          idx    <= idx + CNT_W'(1);
        end else begin
          rd_v <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur       <= q_item;
            r_status  <= ST_OK;
            r_verdict <= 8'd0;
            r_rsrc    <= RS_NONE;
            r_rtag    <= '0;
            r_evv     <= 1'b0;
            r_evt     <= '0;
            idx       <= '0;
            rd_v      <= 1'b0;
            found     <= 1'b0;
            rfound    <= 1'b0;
            scan_n    <= used;
            case (q_item.op)
              OP_LOOKUP: begin
                acc   <= acc + 64'd1;
                state <= q_item.rev ? S_REV_SCAN : S_FULL_SCAN;
              end
              OP_ADD: begin
                acc   <= acc + 64'd1;
                state <= S_DUP_SCAN;
              end
              OP_BAD_ADD: begin
                r_status <= ST_BADV;
                state    <= S_RESP;
              end
              OP_CLEAR: begin
                used  <= '0;
                mark  <= '0;
                state <= S_RESP;
              end
              default: state <= S_RESP;
            endcase
          end
        end

        S_REV_SCAN: begin
          if (rd_v && rdir_hit && !found) begin
            found <= 1'b1;
            fidx  <= rd_idx;
            fver  <= ver_rd;
            ftag  <= tag_rd;
          end
          if (scan_done) begin
            if (found) begin
              r_rsrc <= RS_TAG;
              r_rtag <= ftag;
            end
            r_verdict <= rev_v;
            if (rev_v == cfg.miss_code) begin
              acc   <= acc + 64'd1;
              idx   <= '0;
              found <= 1'b0;
              state <= S_FULL_SCAN;
            end else begin
              state <= S_RESP;
            end
          end
        end

        S_FULL_SCAN: begin
          if (rd_v && full_hit && !found) begin
            found <= 1'b1;
            fidx  <= rd_idx;
            fver  <= ver_rd;
          end
          if (scan_done) begin
            r_verdict <= hit_v;
            if (is_redir(hit_v, cfg)) begin
              r_rsrc <= RS_PKT;
              r_rtag <= '0;
            end
            state <= S_RESP;
          end
        end

        S_DUP_SCAN: begin
          if (rd_v && full_hit && !found) found <= 1'b1;
          if (rd_v && rdir_hit && !rfound) begin
            rfound <= 1'b1;
            rslot  <= rd_idx;
          end
          if (scan_done) begin
            if (found) begin
              r_status <= ST_DUP;
              state    <= S_RESP;
            end else if (used < CNT_W'(ENTRIES)) begin
              wslot <= used[IDX_W-1:0];
              used  <= used + CNT_W'(1);
              state <= S_WRITE;
            end else begin
              idx    <= '0;
              scan_n <= CNT_W'(ENTRIES);
              state  <= S_EVICT_SCAN;
            end
          end
        end

        S_EVICT_SCAN: begin
          // strict less keeps the lowest slot on ties
          if (rd_v && (!found || stamp_rd < fmin)) begin
            found <= 1'b1;
            fmin  <= stamp_rd;
            fidx  <= rd_idx;
            ftag  <= tag_rd;
          end
          if (scan_done) begin
            wslot <= fidx;
            r_evv <= 1'b1;
            r_evt <= ftag;
            state <= S_WRITE;
          end
        end

        S_WRITE: begin
          mark[wslot] <= new_mark;
          state       <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= r_status;
            verdict         <= r_verdict;
            redirect_source <= r_rsrc;
            redirect_tag    <= 16'(r_rtag);
            evicted_valid   <= r_evv;
            evicted_tag     <= 16'(r_evt);
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/flow_verdict_lru_cache_unit.sv =====
// flow verdict cache top: front end, queue and engine; lookups scan the used slots,
// after a reverse scan when inbound to a trigger port; adds scan for a duplicate,
// then search all 64 slots for a victim when full; clear and refused adds skip scans.
// one item is worked at a time in the engine, its slot scan sets the rate
// reset clears control, registers, counters and redirect marks; entries read empty
`include "assert_macros.svh"
module flow_verdict_lru_cache_unit import fvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] local_addr_hi,
  input  logic [63:0] local_addr_lo,
  input  logic [63:0] remote_addr_hi,
  input  logic [63:0] remote_addr_lo,
  input  logic [15:0] local_port,
  input  logic [15:0] remote_port,
  input  logic [7:0]  protocol,
  input  logic        inbound,
  input  logic [7:0]  new_verdict,
  input  logic [15:0] context_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  verdict,
  output logic [1:0]  redirect_source,
  output logic [15:0] redirect_tag,
  output logic        evicted_valid,
  output logic [15:0] evicted_tag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  item_t f_item;
  item_t q_item;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;
  stat_t stat;

  fvc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .action, .local_addr_hi, .local_addr_lo,
    .remote_addr_hi, .remote_addr_lo, .local_port, .remote_port, .protocol,
    .inbound, .new_verdict, .context_tag, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .q_full, .push, .item(f_item), .cfg
  );

  fvc_queue u_queue (
    .clk, .rst, .push, .push_item(f_item), .pop, .head(q_item),
    .empty(q_empty), .full(q_full)
  );

  fvc_back u_back (
    .clk, .rst, .cfg, .q_item, .q_empty, .pop, .stat, .out_valid, .out_stall,
    .status, .verdict, .redirect_source, .redirect_tag, .evicted_valid, .evicted_tag
  );

  // checks
  `FVC_ASSERT(a_used_range, stat.used <= CNT_W'(ENTRIES), "slot count above capacity")
  `FVC_IMPLY(a_full_stalls, q_full, in_stall && !push, "beat taken into a full queue")
  `FVC_IMPLY(a_rose_busy, $rose(out_valid), $past(stat.busy), "result without work")
  `FVC_IMPLY(a_pop_nonempty, pop, !q_empty, "pop from an empty queue")

endmodule

// ===== bench/flow_verdict_lru_cache_unit_tb.sv =====
// testbench for flow_verdict_lru_cache_unit: directed and random flow beats
// checked against an in-bench model of the lru verdict cache; uses fvc_pkg
`timescale 1ns / 1ps
module flow_verdict_lru_cache_unit_tb;
  import fvc_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POOL_SIZE = 48;

  typedef struct {
    logic [1:0]  action;
    key_t        key;
    logic        inbound;
    logic [7:0]  nv;
    logic [15:0] tag;
  } flow_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  verdict;
    logic [1:0]  rsrc;
    logic [15:0] rtag;
    logic        evv;
    logic [15:0] evt;
  } flow_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = '0;
  logic [63:0] local_addr_hi = '0;
  logic [63:0] local_addr_lo = '0;
  logic [63:0] remote_addr_hi = '0;
  logic [63:0] remote_addr_lo = '0;
  logic [15:0] local_port = '0;
  logic [15:0] remote_port = '0;
  logic [7:0]  protocol = '0;
  logic        inbound = 1'b0;
  logic [7:0]  new_verdict = '0;
  logic [15:0] context_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  verdict;
  logic [1:0]  redirect_source;
  logic [15:0] redirect_tag;
  logic        evicted_valid;
  logic [15:0] evicted_tag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  flow_verdict_lru_cache_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  key_t        ent_key[ENTRIES];
  logic [7:0]  ent_verdict[ENTRIES];
  logic [15:0] ent_tag[ENTRIES];
  logic [63:0] ent_stamp[ENTRIES];
  bit          ent_rdx[ENTRIES];
  int          ent_used;
  logic [63:0] access_ctr;
  cfg_t        cfg_model;

  flow_rsp_t expected_rsps[$];
  key_t      key_pool[POOL_SIZE];
  int        errors = 0;
  bit        calm = 1'b0;
  int        idle_cycles = 0;

  function automatic bit is_redirect_code(logic [7:0] v);
    return (v == cfg_model.dns_code) || (v == cfg_model.tunnel_code);
  endfunction

  function automatic int find_flow(key_t k);
    for (int i = 0; i < ent_used; i++)
      if (ent_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_reverse(key_t k);
    for (int i = 0; i < ent_used; i++)
      if (ent_rdx[i] && ent_key[i].lhi == k.lhi && ent_key[i].llo == k.llo &&
          ent_key[i].lport == k.lport && ent_key[i].proto == k.proto)
        return i;
    return -1;
  endfunction

  // advance the cache model by one request and give its response
  function automatic flow_rsp_t predict_flow(flow_req_t r);
    flow_rsp_t o;
    int s;
    int f;
    logic [7:0] v;
    o = '{default: '0};
    case (r.action)
      ACT_ADD: begin
        if (r.nv == 8'd0) begin
          o.status = ST_BADV;
        end else begin
          access_ctr++;
          if (find_flow(r.key) >= 0) begin
            o.status = ST_DUP;
          end else begin
            if (ent_used < ENTRIES) begin
              s = ent_used;
              ent_used++;
            end else begin
              // lru victim, lowest slot wins ties
              s = 0;
              for (int i = 1; i < ENTRIES; i++)
                if (ent_stamp[i] < ent_stamp[s]) s = i;
              o.evv = 1'b1;
              o.evt = ent_tag[s];
            end
            ent_rdx[s] = 1'b0;
            ent_key[s] = r.key;
            ent_verdict[s] = r.nv;
            ent_tag[s] = r.tag;
            ent_stamp[s] = access_ctr;
            if (is_redirect_code(r.nv) && find_reverse(r.key) < 0) ent_rdx[s] = 1'b1;
          end
        end
      end
      ACT_LOOKUP: begin
        v = cfg_model.miss_code;
        // reverse try for inbound packets to the trigger ports
        if (r.inbound && (r.key.rport == cfg_model.tunnel_port ||
                          r.key.rport == cfg_model.dns_port)) begin
          access_ctr++;
          f = find_reverse(r.key);
          if (f >= 0) begin
            ent_stamp[f] = access_ctr;
            o.rsrc = RS_TAG;
            o.rtag = ent_tag[f];
            v = ent_verdict[f];
          end
          if (!is_redirect_code(v)) v = cfg_model.miss_code;
        end
        if (v == cfg_model.miss_code) begin
          access_ctr++;
          f = find_flow(r.key);
          v = cfg_model.miss_code;
          if (f >= 0) begin
            ent_stamp[f] = access_ctr;
            v = ent_verdict[f];
          end
          if (is_redirect_code(v)) begin
            o.rsrc = RS_PKT;
            o.rtag = '0;
          end
        end
        o.verdict = v;
      end
      ACT_CLEAR: begin
        ent_used = 0;
        for (int i = 0; i < ENTRIES; i++) ent_rdx[i] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.lhi = {$urandom, $urandom};
    k.llo = {$urandom, $urandom};
    k.rhi = {$urandom, $urandom};
    k.rlo = {$urandom, $urandom};
    k.lport = $urandom;
    k.rport = $urandom;
    k.proto = $urandom;
    return k;
  endfunction

  function automatic flow_req_t make_req(logic [1:0] act, key_t k, logic inb,
                                         logic [7:0] nv, logic [15:0] tag);
    flow_req_t r;
    r.action = act;
    r.key = k;
    r.inbound = inb;
    r.nv = nv;
    r.tag = tag;
    return r;
  endfunction

  // drive one beat, wait for acceptance, record its expected response
  task automatic send_item(flow_req_t r);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.action;
    local_addr_hi <= r.key.lhi;
    local_addr_lo <= r.key.llo;
    remote_addr_hi <= r.key.rhi;
    remote_addr_lo <= r.key.rlo;
    local_port <= r.key.lport;
    remote_port <= r.key.rport;
    protocol <= r.key.proto;
    inbound <= r.inbound;
    new_verdict <= r.nv;
    context_tag <= r.tag;
    do @(posedge clk); while (in_stall);
    expected_rsps.push_back(predict_flow(r));
  endtask

  // stop sending and wait until every response has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all five registers back to back; only call when drained
  task automatic set_config(logic [7:0] miss, logic [7:0] dns_c, logic [7:0] tun_c,
                            logic [15:0] tun_p, logic [15:0] dns_p);
    logic [15:0] vals[5];
    logic [2:0]  idxs[5];
    idxs = '{CFG_MISS, CFG_DNS_CODE, CFG_TUNNEL_CODE, CFG_TUNNEL_PORT, CFG_DNS_PORT};
    vals = '{{8'($urandom), miss}, {8'($urandom), dns_c}, {8'($urandom), tun_c},
             tun_p, dns_p};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_model.miss_code = miss;
    cfg_model.dns_code = dns_c;
    cfg_model.tunnel_code = tun_c;
    cfg_model.tunnel_port = tun_p;
    cfg_model.dns_port = dns_p;
  endtask

  // response checker, output stall and watchdog
  always @(posedge clk) begin
    flow_rsp_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 31);
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response beat with nothing expected");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++;
          end
          if (verdict !== e.verdict) begin
            $error("verdict exp %0d got %0d", e.verdict, verdict); errors++;
          end
          if (redirect_source !== e.rsrc) begin
            $error("redirect_source exp %0d got %0d", e.rsrc, redirect_source); errors++;
          end
          if (redirect_tag !== e.rtag) begin
            $error("redirect_tag exp %0h got %0h", e.rtag, redirect_tag); errors++;
          end
          if (evicted_valid !== e.evv) begin
            $error("evicted_valid exp %0d got %0d", e.evv, evicted_valid); errors++;
          end
          if (evicted_tag !== e.evt) begin
            $error("evicted_tag exp %0h got %0h", e.evt, evicted_tag); errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // extremes, every action, bad verdict, duplicate, reverse hit, collision, clear
  task automatic test_directed();
    key_t a;
    key_t b;
    key_t c;
    a = random_key();
    a.rport = 16'd53;
    b = '{default: '1};
    c = a;
    c.rhi = ~a.rhi;
    c.rport = 16'd7;
    send_item(make_req(ACT_ADD, a, 1'b0, 8'd0, 16'h1234));
    send_item(make_req(ACT_ADD, '0, 1'b1, 8'd255, 16'h0000));
    send_item(make_req(ACT_ADD, b, 1'b0, 8'd200, 16'hffff));
    send_item(make_req(ACT_ADD, b, 1'b1, 8'd201, 16'h5555));
    send_item(make_req(ACT_LOOKUP, b, 1'b1, 8'd0, 16'h0));
    send_item(make_req(ACT_LOOKUP, '0, 1'b0, 8'hff, 16'hffff));
    send_item(make_req(ACT_LOOKUP, random_key(), 1'b0, 8'd3, 16'h1));
    send_item(make_req(ACT_ADD, a, 1'b0, 8'd1, 16'hbeef));
    send_item(make_req(ACT_ADD, c, 1'b0, 8'd2, 16'hcafe));
    send_item(make_req(ACT_LOOKUP, a, 1'b0, 8'd0, 16'h0));
    c.rhi = 64'h0;
    c.rport = 16'd53;
    send_item(make_req(ACT_LOOKUP, c, 1'b1, 8'd0, 16'h0));
    c.rport = 16'd0;
    send_item(make_req(ACT_LOOKUP, c, 1'b1, 8'd0, 16'h0));
    send_item(make_req(ACT_LOOKUP, c, 1'b0, 8'd0, 16'h0));
    send_item(make_req(ACT_IGNORED, b, 1'b1, 8'hff, 16'hffff));
    send_item(make_req(ACT_CLEAR, a, 1'b0, 8'd5, 16'h2));
    send_item(make_req(ACT_LOOKUP, a, 1'b0, 8'd0, 16'h0));
    send_item(make_req(ACT_LOOKUP, b, 1'b1, 8'd0, 16'h0));
    drain();
  endtask

  // reverse hit after the redirect codes and trigger ports are rewritten
  task automatic test_code_change();
    key_t a;
    key_t q;
    a = random_key();
    send_item(make_req(ACT_ADD, a, 1'b0, 8'd1, 16'h7777));
    drain();
    set_config(8'd255, 8'd255, 8'd1, 16'hffff, 16'h0000);
    q = a;
    q.rlo = ~a.rlo;
    q.rport = 16'hffff;
    send_item(make_req(ACT_LOOKUP, q, 1'b1, 8'd0, 16'h0));
    q.rport = 16'h0000;
    send_item(make_req(ACT_LOOKUP, q, 1'b1, 8'd0, 16'h0));
    send_item(make_req(ACT_LOOKUP, a, 1'b0, 8'd0, 16'h0));
    send_item(make_req(ACT_LOOKUP, random_key(), 1'b0, 8'd0, 16'h0));
    drain();
    set_config(8'd0, 8'd1, 8'd255, 16'h0000, 16'hffff);
    q.rport = 16'hffff;
    send_item(make_req(ACT_LOOKUP, q, 1'b1, 8'd0, 16'h0));
    send_item(make_req(ACT_CLEAR, q, 1'b0, 8'd0, 16'h0));
    drain();
  endtask

  // overfill the cache so the lru victim search runs with stamp changes
  task automatic test_eviction();
    key_t ks[80];
    for (int i = 0; i < 80; i++) begin
      ks[i] = random_key();
      send_item(make_req(ACT_ADD, ks[i], 1'b0, 8'($urandom_range(1, 255)), 16'($urandom)));
      if (i > 60 && i % 4 == 0)
        send_item(make_req(ACT_LOOKUP, ks[$urandom_range(i)], 1'b0, 8'd0, 16'h0));
    end
    send_item(make_req(ACT_CLEAR, ks[0], 1'b0, 8'd0, 16'h0));
    drain();
  endtask

  // random beats over a key pool so hits, duplicates and collisions occur
  task automatic test_random(int n);
    flow_req_t r;
    int sel;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = random_key();
      if (i > 0 && $urandom_range(2) == 0) begin
        key_pool[i].lhi = key_pool[i-1].lhi;
        key_pool[i].llo = key_pool[i-1].llo;
        key_pool[i].lport = key_pool[i-1].lport;
        key_pool[i].proto = key_pool[i-1].proto;
      end
      case ($urandom_range(2))
        0: key_pool[i].rport = cfg_model.tunnel_port;
        1: key_pool[i].rport = cfg_model.dns_port;
        default: ;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 3 + 80);
      r = make_req(ACT_LOOKUP, ($urandom_range(9) < 7) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                   : random_key(), 1'($urandom), 8'($urandom), 16'($urandom));
      sel = $urandom_range(99);
      if (sel < 46) begin
        if ($urandom_range(3) == 0) begin
          r.key.rhi = {$urandom, $urandom};
          r.key.rport = $urandom_range(1) ? cfg_model.tunnel_port : cfg_model.dns_port;
        end
      end else if (sel < 94) begin
        r.action = ACT_ADD;
        case ($urandom_range(4))
          0: r.nv = cfg_model.dns_code;
          1: r.nv = cfg_model.tunnel_code;
          2: r.nv = cfg_model.miss_code;
          default: if ($urandom_range(7) == 0) r.nv = 8'd0;
        endcase
      end else if (sel < 95) begin
        r.action = ACT_CLEAR;
      end else begin
        r.action = ACT_IGNORED;
      end
      send_item(r);
      if (i == n / 2) drain();
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    cfg_model = '{miss_code: 8'd0, dns_code: 8'd1, tunnel_code: 8'd2,
                  tunnel_port: 16'd0, dns_port: 16'd53};
    ent_used = 0;
    access_ctr = '0;
    for (int i = 0; i < ENTRIES; i++) ent_rdx[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_code_change();
    set_config(8'd0, 8'd1, 8'd2, 16'd0, 16'd53);
    test_eviction();
    test_random(380);
    set_config(8'd255, 8'd255, 8'd1, 16'hffff, 16'h0000);
    test_random(380);
    set_config(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               16'($urandom), 16'($urandom));
    test_random(380);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
